[hw/rtl/framed_packet_receiver_macros.svh]
// Assertion macros used by the framed packet receiver port-level checker.
`ifndef FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/fpr_pkg.sv]
// Types and constants of the framed packet receiver.
package fpr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int INDEX_LIMIT = 64;
   localparam logic [BYTE_W-1:0] CSUM_MASK = 8'h7f;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEAD = 1'b0,
      REG_END  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      STAT_IGNORED  = 3'd0,
      STAT_STARTED  = 3'd1,
      STAT_STORED   = 3'd2,
      STAT_DROPPED  = 3'd3,
      STAT_FRAME_OK = 3'd4,
      STAT_CSUM_BAD = 3'd5,
      STAT_OVERFLOW = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

endpackage

[hw/rtl/fpr_ifs.sv]
// Request and response channel interfaces of the framed packet receiver.
interface fpr_req_if;
   logic                       valid;
   logic                       ready;
   logic [fpr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [fpr_pkg::BYTE_W-1:0] data_byte;
   logic                       last;

   modport source (output valid, output status, output data_byte, output last, input ready);
   modport sink (input valid, input status, input data_byte, input last, output ready);
endinterface

[hw/rtl/framed_packet_receiver.sv]
// Framed packet receiver: a byte equal to the head register opens a frame, following bytes
// are kept in an on-chip frame store, and a byte equal to the end register closes the frame
// and checks it (the low 7 bits of the sum of all stored bytes but the last must equal the
// last stored byte). A good frame is sent out as one response per stored byte, in order,
// with last set on the final one; every other byte gives one status response. The end
// byte of a good frame holds off the request channel while the frame is read out, because
// the frame store has one read port and gives one entry per cycle while the response
// channel is not stalled. There is a single response register and a new byte is taken
// only when it is empty or empties in that same cycle, so a stalled response channel
// stalls the request channel as well. The frame store needs no clearing after reset; the
// head and end registers reset to zero.
module framed_packet_receiver #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [fpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpr_pkg::BYTE_W-1:0]    csr_wdata,
   fpr_req_if.sink                       req_if,
   fpr_rsp_if.source                     rsp_if
);
   import fpr_pkg::*;

   localparam int CNT_W = $clog2(STORE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH - 1);

   state_type          state_ff, state_in;
   logic               frame_open_ff, frame_open_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  last_stored_ff, last_stored_in;
   logic [BYTE_W-1:0]  head_ff, head_in;
   logic [BYTE_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               accept;
   logic               room;
   logic               csum_ok;
   logic               at_last;
   logic [BYTE_W-1:0]  rx;
   logic [BYTE_W-1:0]  body;
   logic               wr_en;
   logic [CNT_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]  rd_data;

   fpr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (rx),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rx       = req_if.rx_byte;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_if.valid && req_if.ready;
   assign room     = count_ff < CNT_FULL;
   assign body     = (sum_ff - last_stored_ff) & CSUM_MASK;
   assign csum_ok  = (count_ff != '0) && (body == last_stored_ff);
   assign at_last  = idx_ff == (count_ff - CNT_W'(1));

   always_comb begin
      head_in = head_ff;
      end_in  = end_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_HEAD: head_in = csr_wdata;
            REG_END:  end_in  = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      frame_open_in  = frame_open_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      last_stored_in = last_stored_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      rd_addr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rx;
               rsp_last_in  = 1'b1;
               if (int'(count_ff) >= INDEX_LIMIT) begin
                  frame_open_in = 1'b0;
                  count_in      = '0;
                  sum_in        = '0;
                  rsp_status_in = STAT_OVERFLOW;
               end else if (rx == head_ff) begin
                  frame_open_in = 1'b1;
                  count_in      = '0;
                  sum_in        = '0;
                  rsp_status_in = STAT_STARTED;
               end else if (!frame_open_ff) begin
                  rsp_status_in = STAT_IGNORED;
               end else if (rx == end_ff) begin
                  frame_open_in = 1'b0;
                  if (csum_ok) begin
                     // Read out the frame; first entry is read at this edge.
                     rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
                     rsp_status_in = rsp_status_ff;
                     rsp_data_in   = rsp_data_ff;
                     rsp_last_in   = rsp_last_ff;
                     state_in      = ST_SEND;
                  end else begin
                     wr_en         = room;
                     rsp_status_in = STAT_CSUM_BAD;
                  end
               end else begin
                  wr_en         = room;
                  rsp_status_in = room ? STAT_STORED : STAT_DROPPED;
               end
               if (wr_en) begin
                  count_in       = count_ff + CNT_W'(1);
                  sum_in         = sum_ff + rx;
                  last_stored_in = rx;
               end
            end
         end
         ST_SEND: begin
            rd_addr = idx_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FRAME_OK;
               rsp_data_in   = rd_data;
               rsp_last_in   = at_last;
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = idx_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Read data reflects the entry at idx_ff in ST_SEND, where nothing is written.
   assign idx_in = rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_open_ff  <= 1'b0;
         count_ff       <= '0;
         sum_ff         <= '0;
         last_stored_ff <= '0;
         head_ff        <= '0;
         end_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_open_ff  <= frame_open_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         last_stored_ff <= last_stored_in;
         head_ff        <= head_in;
         end_ff         <= end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.data_byte = rsp_data_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule

[hw/rtl/fpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fpr_checker.sv]
// Port-level checker for the framed packet receiver, bound to the top level.
`include "framed_packet_receiver_macros.svh"

module fpr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_status,
   input logic [fpr_pkg::BYTE_W-1:0] rsp_data_byte,
   input logic                       rsp_last
);
   import fpr_pkg::*;

   logic frame_mid;
   logic status_resp;

   assign frame_mid   = rsp_valid && (rsp_status == STAT_FRAME_OK) && !rsp_last;
   assign status_resp = rsp_valid && (rsp_status != STAT_FRAME_OK);

   // Hold a stalled response.
   `FPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_byte) && $stable(rsp_last), "stalled response changed")

   // No new transaction on the request side while a frame is still being sent.
   `FPR_ASSERT_NOW(a_no_req_mid_frame, clock, reset, frame_mid, !req_ready, "request taken during frame readout")

   `FPR_ASSERT_NOW(a_status_single, clock, reset, status_resp, rsp_last, "status response without last")

   // A frame readout continues with another frame byte.
   `FPR_ASSERT_NEXT(a_frame_continues, clock, reset, frame_mid && rsp_ready, !rsp_valid || (rsp_status == STAT_FRAME_OK), "frame readout interrupted")

   // An accepted transaction leaves a response behind or starts a frame readout.
   `FPR_ASSERT_NEXT(a_req_answered, clock, reset, req_valid && req_ready, rsp_valid || !req_ready, "request transaction left no response")

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_data_byte (rsp_if.data_byte),
   .rsp_last      (rsp_if.last)
);

[tb/framed_packet_receiver_checker.sv]
// Checker for the framed packet receiver: tracks registers, predicts responses and compares them.
module framed_packet_receiver_checker #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [fpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpr_pkg::BYTE_W-1:0]    csr_wdata,
   fpr_req_if                            req_if,
   fpr_rsp_if                            rsp_if,
   output int                            error_count,
   output int                            pending_count,
   output int                            checked_count
);
   import fpr_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);

   typedef struct packed {
      status_type  status;
      logic [7:0]  data_byte;
      logic        last;
   } rsp_fields_type;

   rsp_fields_type due_rsps[$];

   logic [7:0] head_reg;
   logic [7:0] end_reg;
   logic       in_frame;
   logic [6:0] stored_count;
   logic [7:0] frame_bytes[STORE_DEPTH];
   logic [7:0] byte_sum;
   logic [7:0] newest_byte;
   int         mismatches;
   int         checked;

   function automatic void owe_rsp(status_type st, logic [7:0] data, logic last);
      rsp_fields_type r;
      r.status    = st;
      r.data_byte = data;
      r.last      = last;
      due_rsps.push_back(r);
   endfunction

   // Store one byte if the frame store has room left.
   function automatic logic keep_byte(logic [7:0] b);
      if (stored_count >= STORE_DEPTH - 1)
         return 1'b0;
      frame_bytes[stored_count[IDX_W-1:0]] = b;
      stored_count = stored_count + 7'd1;
      byte_sum = byte_sum + b;
      newest_byte = b;
      return 1'b1;
   endfunction

   task automatic frame_rx_step(input logic [7:0] b);
      logic [7:0] body;
      int         n;
      body = (byte_sum - newest_byte) & CSUM_MASK;
      if (stored_count >= INDEX_LIMIT) begin
         in_frame = 1'b0;
         stored_count = '0;
         byte_sum = '0;
         owe_rsp(STAT_OVERFLOW, b, 1'b1);
      end else if (b == head_reg) begin
         in_frame = 1'b1;
         stored_count = '0;
         byte_sum = '0;
         owe_rsp(STAT_STARTED, b, 1'b1);
      end else if (!in_frame) begin
         owe_rsp(STAT_IGNORED, b, 1'b1);
      end else if (b == end_reg) begin
         in_frame = 1'b0;
         if (stored_count > 0 && body == newest_byte) begin
            n = (stored_count > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : int'(stored_count);
            for (int i = 0; i < n; i++)
               owe_rsp(STAT_FRAME_OK, frame_bytes[i], i == n - 1);
         end else begin
            // a failed frame still keeps its end byte
            void'(keep_byte(b));
            owe_rsp(STAT_CSUM_BAD, b, 1'b1);
         end
      end else if (keep_byte(b)) begin
         owe_rsp(STAT_STORED, b, 1'b1);
      end else begin
         owe_rsp(STAT_DROPPED, b, 1'b1);
      end
   endtask

   task automatic check_rsp();
      rsp_fields_type want;
      if (due_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: status %0d data %02h last %0d",
                     rsp_if.status, rsp_if.data_byte, rsp_if.last);
      end else begin
         want = due_rsps.pop_front();
         checked++;
         if (rsp_if.status !== want.status || rsp_if.data_byte !== want.data_byte ||
             rsp_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d data %02h last %0d, got %0d %02h %0d",
                        want.status, want.data_byte, want.last,
                        rsp_if.status, rsp_if.data_byte, rsp_if.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_rsps.delete();
         head_reg = '0;
         end_reg = '0;
         in_frame = 1'b0;
         stored_count = '0;
         byte_sum = '0;
         newest_byte = '0;
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_rsp();
         if (req_if.valid && req_if.ready)
            frame_rx_step(req_if.rx_byte);
         if (csr_write_en) begin
            case (csr_index)
               REG_HEAD: head_reg = csr_wdata;
               REG_END:  end_reg = csr_wdata;
               default:  ;
            endcase
         end
      end
      error_count <= mismatches;
      pending_count <= due_rsps.size();
      checked_count <= checked;
   end

endmodule

[tb/framed_packet_receiver_test.sv]
// Top of the framed packet receiver testbench: clock, reset, stimulus and verdict.
module framed_packet_receiver_test;
   import fpr_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int BYTE_TARGET = 460;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   fpr_req_if req_if();
   fpr_rsp_if rsp_if();

   int         error_count;
   int         pending_count;
   int         checked_count;
   int         cycles = 0;
   int         bytes_sent;
   int         settings_used;
   bit         quiet;
   logic [7:0] head_val;
   logic [7:0] end_val;

   framed_packet_receiver dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_if       (req_if),
      .rsp_if       (rsp_if)
   );

   framed_packet_receiver_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   // Response side: stall a random number of cycles before each transaction.
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      bytes_sent++;
   endtask

   // Hold off the request side until every owed response has arrived.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frame_bytes(input logic [7:0] h, input logic [7:0] e);
      head_val = h;
      end_val = e;
      csr_write_en <= 1'b1;
      csr_index <= REG_HEAD;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= REG_END;
      csr_wdata <= e;
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == head_val || b == end_val)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // Head, payload, checksum byte (corrupted unless good), end.
   task automatic send_frame(input int len, input bit good);
      logic [7:0] b;
      logic [7:0] total;
      logic [7:0] csum;
      total = '0;
      send_byte(head_val);
      for (int i = 0; i < len; i++) begin
         b = payload_byte();
         total = total + b;
         send_byte(b);
      end
      csum = total & CSUM_MASK;
      if (!good)
         csum = csum ^ 8'($urandom_range(1, 127));
      send_byte(csum);
      send_byte(end_val);
   endtask

   function automatic int draw_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(0, 8);
      else if (r < 95)
         return $urandom_range(9, 40);
      return $urandom_range(55, 66);
   endfunction

   initial begin
      int phase;
      int phase_end;
      int r;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = REG_HEAD;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      bytes_sent = 0;
      settings_used = 0;
      quiet = 1'b0;
      head_val = '0;
      end_val = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_frame_bytes(8'hA5, 8'h5A);
      // bytes outside a frame, including the end byte
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      // empty frame counts as a checksum failure
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      send_byte(8'h5A);
      // sum wraps past 8 bits before the mask
      send_byte(8'hA5);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h7E);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(8'h5A);
      // head inside an open frame restarts it
      send_byte(8'hA5);
      send_byte(8'hA5);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h5A);

      phase = 0;
      while (bytes_sent < BYTE_TARGET) begin
         drain();
         case (phase)
            0:       set_frame_bytes(8'h00, 8'hFF);
            1:       set_frame_bytes(8'hFF, 8'h00);
            2:       set_frame_bytes(8'h80, 8'h7F);
            3:       set_frame_bytes(8'h3C, 8'h3C);
            4:       set_frame_bytes(8'h00, 8'h00);
            default: begin
               r = $urandom_range(0, 255);
               set_frame_bytes(8'(r), ($urandom_range(0, 5) == 0) ? 8'(r)
                                                                 : 8'($urandom_range(0, 255)));
            end
         endcase
         quiet = (phase % 3 == 2);
         if (phase == 0) begin
            // longest good frame, then one that overfills the store
            send_frame(62, 1'b1);
            send_frame(66, 1'b1);
         end
         phase_end = bytes_sent + 50;
         while (bytes_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               send_frame(draw_len(), $urandom_range(0, 4) != 0);
            end else if (r < 72) begin
               send_byte(head_val);
               send_byte(end_val);
            end else if (r < 78) begin
               send_byte(head_val);
               repeat ($urandom_range(0, 4)) send_byte(payload_byte());
               send_frame($urandom_range(0, 6), 1'b1);
            end else if (r < 90) begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end else if (r < 97) begin
               send_byte(head_val);
               repeat ($urandom_range(0, 6)) send_byte(payload_byte());
            end else begin
               drain();
            end
         end
         phase++;
      end

      quiet = 1'b0;
      drain();
      repeat (70) @(posedge clock);
      $display("Summary: %0d bytes sent under %0d head/end settings, %0d responses checked",
               bytes_sent, settings_used, checked_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_ifs.sv
hw/rtl/fpr_ram.sv
hw/rtl/framed_packet_receiver.sv
hw/rtl/fpr_checker.sv
tb/framed_packet_receiver_checker.sv
tb/framed_packet_receiver_test.sv
